[rtl/core/bffa_pkg.sv]
package bffa_pkg;

  // default bitmap size in units
  localparam int BITMAP_BITS_DEF = 4096;

  // field widths
  localparam int CMD_W   = 2;
  localparam int UNIT_W  = 12;
  localparam int WIDX_W  = 7;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 13;

  // total_units after reset
  localparam logic [COUNT_W-1:0] TOTAL_UNITS_RST = 13'd4096;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_WORD  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_COUNT = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_t;

endpackage

[rtl/core/bitmap_first_fit_allocator.sv]
// First-fit bitmap allocator. Holds a usage bitmap of BITMAP_BITS units (unit i in bit i mod 32
// of word i/32, set = in use) in a one-write one-read RAM, plus a saturating free counter.
// Commands: allocate hands out the lowest clear unit below min(total_units, BITMAP_BITS),
// free clears a unit's bit, and two load commands preset one bitmap word or the counter.
// Every command word gives exactly one response word. After reset the block clears the bitmap,
// one RAM word a cycle, with cmd_stall high; total_units may be written meanwhile. Both loads,
// an out-of-range free and an allocate with the counter at zero load the response register at
// acceptance; a free reads the unit's word at acceptance, then writes it back with the bit
// cleared and responds; an allocate reads bitmap words in turn, one word a cycle, through the
// single RAM read port and one priority encoder, and responds at the first word holding a clear
// unit below the limit, or fails at the limit or the last word. One command is in flight at a
// time; a new command is taken while the previous response is being taken from the response
// register.
module bitmap_first_fit_allocator
  import bffa_pkg::*;
#(
  parameter int BITMAP_BITS = BITMAP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  // command channel
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [UNIT_W-1:0]  unit_index,
  input  logic [WIDX_W-1:0]  word_index,
  input  logic [WORD_W-1:0]  word_value,
  input  logic [COUNT_W-1:0] count_value,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               success,
  output logic [UNIT_W-1:0]  granted_index,
  output logic [COUNT_W-1:0] free_left
);

  localparam int MAP_WORDS = (BITMAP_BITS + 31) / 32;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(BITMAP_BITS + 1);
  // wide enough for limits, word bases and every field compared against them
  localparam int WD        = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

  localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [WD-1:0]    BITS_W    = WD'(BITMAP_BITS);
  localparam logic [WD-1:0]    WORDS_W   = WD'(MAP_WORDS);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(BITMAP_BITS);

  // sequencer and control registers
  state_t            state, state_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic [AW-1:0]     scan_word, scan_word_next;
  logic [CNT_W-1:0]  free_count, count_next;
  logic [COUNT_W-1:0] total_units;
  logic [WD-1:0]     lim_q;
  logic [UNIT_W-1:0] unit_q;

  // bitmap ram port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // response load
  logic               rsp_load;
  logic               success_next;
  logic [UNIT_W-1:0]  granted_next;
  logic [WD-1:0]      count_wide;

  // datapath
  logic              cmd_take;
  logic [WD-1:0]     tot_wide, limit;
  logic [WD-1:0]     unit_wide, unit_word, widx_wide, cnt_in_wide;
  logic [WD-1:0]     q_word_wide;
  logic [WD-1:0]     base, remain, grant_wide;
  logic [WORD_W-1:0] vmask, cand;
  logic [4:0]        hit_bit;

  bffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .ADDR_W(AW)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // effective limit: min(total_units, BITMAP_BITS)
  assign tot_wide    = WD'(total_units);
  assign limit       = (tot_wide < BITS_W) ? tot_wide : BITS_W;
  assign unit_wide   = WD'(unit_index);
  assign unit_word   = unit_wide >> 5;
  assign q_word_wide = WD'(unit_q) >> 5;
  assign widx_wide   = WD'(word_index);
  assign cnt_in_wide = WD'(count_value);

  // word being scanned: base unit, units left below the limit, candidate clear bits
  assign base   = WD'({scan_word, 5'b0});
  assign remain = lim_q - base;
  assign vmask  = (remain >= WD'(32)) ? '1 : ((WORD_W'(1) << remain[4:0]) - WORD_W'(1));
  assign cand   = ~ram_rdata & vmask;

  // lowest set candidate bit
  always_comb begin
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = 5'(b);
      end
    end
  end

  assign grant_wide = base + WD'(hit_bit);

  // ready in idle once the response register is free or being emptied
  assign cmd_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign cmd_take  = cmd_valid && !cmd_stall;

  // sequencer
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    scan_word_next = scan_word;
    count_next     = free_count;
    ram_we         = 1'b0;
    ram_waddr      = clr_addr;
    ram_wdata      = '0;
    ram_raddr      = scan_word + AW'(1);
    rsp_load       = 1'b0;
    success_next   = 1'b0;
    granted_next   = '0;

    case (state)
      ST_CLEAR: begin
        // zero one bitmap word a cycle
        ram_we        = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_raddr = (command == CMD_FREE) ? unit_word[AW-1:0] : '0;
        if (cmd_take) begin
          case (command)
            CMD_ALLOC: begin
              if (free_count == '0) begin
                rsp_load = 1'b1;
              end else begin
                // word 0 read issued now, checked next cycle
                scan_word_next = '0;
                state_next     = ST_SCAN;
              end
            end
            CMD_FREE: begin
              if (unit_wide < limit) begin
                state_next = ST_FREE;
              end else begin
                rsp_load = 1'b1;
              end
            end
            CMD_LOAD_WORD: begin
              rsp_load = 1'b1;
              if (widx_wide < WORDS_W) begin
                ram_we       = 1'b1;
                ram_waddr    = widx_wide[AW-1:0];
                ram_wdata    = word_value;
                success_next = 1'b1;
              end
            end
            CMD_LOAD_COUNT: begin
              rsp_load     = 1'b1;
              success_next = 1'b1;
              count_next   = (cnt_in_wide > BITS_W) ? CNT_MAX : cnt_in_wide[CNT_W-1:0];
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // ram_rdata holds scan_word; the next word is read meanwhile
        if ((base < lim_q) && (cand != '0)) begin
          ram_we       = 1'b1;
          ram_waddr    = scan_word;
          ram_wdata    = ram_rdata | (WORD_W'(1) << hit_bit);
          count_next   = free_count - CNT_W'(1);
          rsp_load     = 1'b1;
          success_next = 1'b1;
          granted_next = grant_wide[UNIT_W-1:0];
          state_next   = ST_IDLE;
        end else if ((base >= lim_q) || (scan_word == LAST_WORD)) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          scan_word_next = scan_word + AW'(1);
        end
      end

      ST_FREE: begin
        // write back the word read at acceptance with the unit's bit cleared
        ram_we       = 1'b1;
        ram_waddr    = q_word_wide[AW-1:0];
        ram_wdata    = ram_rdata & ~(WORD_W'(1) << unit_q[4:0]);
        count_next   = (free_count < CNT_MAX) ? free_count + CNT_W'(1) : free_count;
        rsp_load     = 1'b1;
        success_next = 1'b1;
        state_next   = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign count_wide = WD'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      scan_word   <= '0;
      free_count  <= '0;
      total_units <= TOTAL_UNITS_RST;
      rsp_valid   <= 1'b0;
    end else begin
      clr_addr   <= clr_addr_next;
      scan_word  <= scan_word_next;
      free_count <= count_next;
      if (cfg_we) begin
        total_units <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command operands and response word, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      lim_q  <= limit;
      unit_q <= unit_index;
    end
    if (rsp_load) begin
      success       <= success_next;
      granted_index <= granted_next;
      free_left     <= count_wide[COUNT_W-1:0];
    end
  end

`ifndef SYNTH
  // no command taken while clearing or working on one
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> cmd_stall)
    else $error("command accepted while busy");

  // counter never passes the bitmap size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_MAX)
    else $error("free counter above bitmap size");

  // a counter load always answers next cycle with success
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && (command == CMD_LOAD_COUNT)) |=> (rsp_valid && success))
    else $error("counter load not answered");

  // a response is never overwritten before it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !rsp_load)
    else $error("pending response overwritten");
`endif

endmodule

[rtl/core/bffa_ram.sv]
module bffa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[dv/bitmap_first_fit_allocator_tb.sv]
module bitmap_first_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bffa_pkg::*;

  localparam int MAP_WORDS = (BITMAP_BITS_DEF + 31) / 32;

  // one command word as offered on the command channel
  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [UNIT_W-1:0]  unit;
    logic [WIDX_W-1:0]  widx;
    logic [WORD_W-1:0]  wval;
    logic [COUNT_W-1:0] cnt;
  } alloc_req_t;

  // one response word
  typedef struct packed {
    logic               ok;
    logic [UNIT_W-1:0]  grant;
    logic [COUNT_W-1:0] left;
  } alloc_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [CMD_W-1:0]   command = '0;
  logic [UNIT_W-1:0]  unit_index = '0;
  logic [WIDX_W-1:0]  word_index = '0;
  logic [WORD_W-1:0]  word_value = '0;
  logic [COUNT_W-1:0] count_value = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic               success;
  logic [UNIT_W-1:0]  granted_index;
  logic [COUNT_W-1:0] free_left;

  bitmap_first_fit_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .unit_index   (unit_index),
    .word_index   (word_index),
    .word_value   (word_value),
    .count_value  (count_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .success      (success),
    .granted_index(granted_index),
    .free_left    (free_left)
  );

  always #5 clk = ~clk;

  // shadow copy of the allocator state, advanced as each command word is taken
  logic [WORD_W-1:0] shadow_map [MAP_WORDS];
  int                shadow_free;
  int                shadow_total;

  alloc_req_t pending_reqs [$];   // words still to be offered
  alloc_rsp_t expected_rsps [$];  // responses owed by the block, oldest first

  int issued_words;    // words put into pending_reqs
  int accepted_words;  // words the block has taken
  int mismatches;

  bit idle_on;         // random gaps on both channels for this phase
  int holds_asked;     // long receiver hold-offs requested
  int holds_served;
  int hold_left;
  int stall_left;
  int send_gap;
  bit cmd_taken;       // the word on the bus was taken at the last rising edge

  alloc_req_t next_req;
  alloc_rsp_t got_rsp;
  alloc_rsp_t want_rsp;

  // gap lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // works out the response to one command and advances the shadow state
  function automatic alloc_rsp_t apply_command(alloc_req_t r);
    alloc_rsp_t o;
    int limit;
    int hit;
    o = '0;
    hit = -1;
    limit = (shadow_total < BITMAP_BITS_DEF) ? shadow_total : BITMAP_BITS_DEF;
    case (r.op)
      CMD_ALLOC: begin
        if (shadow_free != 0) begin
          // first fit: lowest clear bit below the limit, skipping full words
          for (int w = 0; w < MAP_WORDS && hit < 0 && w * 32 < limit; w++) begin
            if (shadow_map[w] != '1) begin
              for (int b = 0; b < 32 && hit < 0 && w * 32 + b < limit; b++) begin
                if (!shadow_map[w][b]) hit = w * 32 + b;
              end
            end
          end
          if (hit >= 0) begin
            shadow_map[hit / 32][hit % 32] = 1'b1;
            shadow_free--;
            o.ok = 1'b1;
            o.grant = UNIT_W'(hit);
          end
        end
      end
      CMD_FREE: begin
        // out-of-range frees are dropped; a double free still counts up
        if (int'(r.unit) < limit) begin
          shadow_map[r.unit / 32][r.unit % 32] = 1'b0;
          if (shadow_free < BITMAP_BITS_DEF) shadow_free++;
          o.ok = 1'b1;
        end
      end
      CMD_LOAD_WORD: begin
        if (int'(r.widx) < MAP_WORDS) begin
          shadow_map[r.widx] = r.wval;
          o.ok = 1'b1;
        end
      end
      default: begin
        // counter preload saturates at the bitmap size
        shadow_free = (int'(r.cnt) > BITMAP_BITS_DEF) ? BITMAP_BITS_DEF : int'(r.cnt);
        o.ok = 1'b1;
      end
    endcase
    o.left = COUNT_W'(shadow_free);
    return o;
  endfunction

  // command driver: new words at the falling edge, held while stalled
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else if (cmd_valid && !cmd_taken) begin
      // word still waiting, payload stays put
    end else if (send_gap > 0) begin
      cmd_valid <= 1'b0;
      send_gap--;
    end else if (pending_reqs.size() > 0) begin
      next_req = pending_reqs.pop_front();
      command <= next_req.op;
      unit_index <= next_req.unit;
      word_index <= next_req.widx;
      word_value <= next_req.wval;
      count_value <= next_req.cnt;
      cmd_valid <= 1'b1;
      send_gap = idle_on ? pick_gap() : 0;
    end else begin
      cmd_valid <= 1'b0;
    end
  end

  // response stall: random gaps, plus the long hold-off when one is asked for
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else if (holds_served != holds_asked) begin
      // long hold-off so that the block backs up onto its command side
      holds_served++;
      hold_left = 400;
      rsp_stall <= 1'b1;
    end else begin
      if (stall_left == 0 && idle_on) stall_left = pick_gap();
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // monitor: check responses first, then predict for a newly taken command
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_valid && !cmd_stall;
      if (rsp_valid && !rsp_stall) begin
        got_rsp.ok = success;
        got_rsp.grant = granted_index;
        got_rsp.left = free_left;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with none owed: success %0b grant %0d free %0d",
                     $realtime, success, granted_index, free_left);
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (got_rsp.ok !== want_rsp.ok || got_rsp.grant !== want_rsp.grant ||
              got_rsp.left !== want_rsp.left) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: success %0b/%0b grant %0d/%0d free %0d/%0d (exp/act)",
                       $realtime, want_rsp.ok, got_rsp.ok, want_rsp.grant, got_rsp.grant,
                       want_rsp.left, got_rsp.left);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        accepted_words++;
        next_req.op = command;
        next_req.unit = unit_index;
        next_req.widx = word_index;
        next_req.wval = word_value;
        next_req.cnt = count_value;
        expected_rsps.push_back(apply_command(next_req));
      end
    end
  end

  task automatic queue_cmd(logic [CMD_W-1:0] op, int unit, int widx, logic [WORD_W-1:0] wval,
                           int cnt);
    alloc_req_t r;
    r.op = op;
    r.unit = UNIT_W'(unit);
    r.widx = WIDX_W'(widx);
    r.wval = wval;
    r.cnt = COUNT_W'(cnt);
    pending_reqs.push_back(r);
    issued_words++;
  endtask

  // wait until every word is taken and every response is back
  task automatic drain();
    do @(negedge clk);
    while (accepted_words != issued_words || expected_rsps.size() != 0);
  endtask

  task automatic set_total(int value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= COUNT_W'(value);
    shadow_total = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random traffic for one setting of total_units
  task automatic random_phase(int n);
    int made;
    int r;
    int limit;
    int k;
    int lo;
    int hi;
    logic [WORD_W-1:0] v;
    made = 0;
    limit = (shadow_total < BITMAP_BITS_DEF) ? shadow_total : BITMAP_BITS_DEF;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 3) begin
        // fill the low words, then allocate: pushes grants high up the map
        k = $urandom_range(MAP_WORDS - 1);
        for (int w = 0; w < k; w++) queue_cmd(CMD_LOAD_WORD, $urandom, w, '1, $urandom);
        queue_cmd(CMD_LOAD_COUNT, $urandom, $urandom, $urandom, $urandom_range(64, 1));
        r = $urandom_range(6, 1);
        for (int i = 0; i < r; i++) queue_cmd(CMD_ALLOC, $urandom, $urandom, $urandom, $urandom);
        made += k + 1 + r;
      end else if (r < 45) begin
        queue_cmd(CMD_ALLOC, $urandom, $urandom, $urandom, $urandom);
        made++;
      end else if (r < 75) begin
        r = $urandom_range(99);
        if (r < 40) begin
          k = $urandom_range(95);
        end else if (r < 80) begin
          // around the limit, so both sides of it are hit
          lo = (limit > 8) ? limit - 8 : 0;
          hi = (limit + 8 < BITMAP_BITS_DEF) ? limit + 8 : BITMAP_BITS_DEF - 1;
          k = $urandom_range(hi, lo);
        end else begin
          k = $urandom_range(BITMAP_BITS_DEF - 1);
        end
        queue_cmd(CMD_FREE, k, $urandom, $urandom, $urandom);
        made++;
      end else if (r < 87) begin
        if ($urandom_range(99) < 60)
          k = $urandom_range(((limit / 32) < MAP_WORDS - 1) ? limit / 32 : MAP_WORDS - 1);
        else
          k = $urandom_range(MAP_WORDS - 1);
        r = $urandom_range(99);
        if (r < 30) v = '1;
        else if (r < 45) v = '0;
        else if (r < 70) v = $urandom;
        else begin
          v = '1;
          v[$urandom_range(31)] = 1'b0;
        end
        queue_cmd(CMD_LOAD_WORD, $urandom, k, v, $urandom);
        made++;
      end else begin
        r = $urandom_range(99);
        if (r < 15) k = 0;
        else if (r < 30) k = $urandom_range(8191, BITMAP_BITS_DEF);
        else if (r < 70) k = $urandom_range(16, 1);
        else k = $urandom_range(BITMAP_BITS_DEF);
        queue_cmd(CMD_LOAD_COUNT, $urandom, $urandom, $urandom, k);
        made++;
      end
    end
  endtask

  // stimulus: reset, directed checks, then random phases over several totals
  initial begin
    int totals [9];
    totals = '{8191, 1, 37, 4095, 100, 0, 1000, 4096, 64};
    foreach (shadow_map[i]) shadow_map[i] = '0;
    shadow_free = 0;
    shadow_total = TOTAL_UNITS_RST;
    idle_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, full range: block still clearing its bitmap while this queues up
    set_total(BITMAP_BITS_DEF);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);                 // counter at zero
    queue_cmd(CMD_LOAD_COUNT, 0, 0, '0, 8191);         // saturates to bitmap size
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);
    queue_cmd(CMD_FREE, 0, 0, '0, 0);
    queue_cmd(CMD_FREE, 0, 0, '0, 0);                  // double free
    queue_cmd(CMD_FREE, 0, 0, '0, 0);                  // counter pinned at the top
    queue_cmd(CMD_FREE, 4095, 127, '1, 8191);
    queue_cmd(CMD_LOAD_WORD, 0, 0, '1, 0);
    queue_cmd(CMD_LOAD_WORD, 0, 1, 32'hAAAA_AAAA, 0);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);
    queue_cmd(CMD_LOAD_WORD, 0, 127, 32'h7FFF_FFFF, 0);
    queue_cmd(CMD_LOAD_COUNT, 0, 0, '0, 0);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);                 // clear bits left, counter empty
    queue_cmd(CMD_LOAD_COUNT, 0, 0, '0, BITMAP_BITS_DEF);
    queue_cmd(CMD_LOAD_WORD, 0, 127, '0, 0);
    queue_cmd(CMD_LOAD_COUNT, 0, 0, '0, 1);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);

    // small total: no clear bit under the limit, free past the limit
    set_total(32);
    queue_cmd(CMD_LOAD_COUNT, 0, 0, '0, 10);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);
    queue_cmd(CMD_FREE, 32, 0, '0, 0);
    queue_cmd(CMD_FREE, 31, 0, '0, 0);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);

    // nothing allocatable at all
    set_total(0);
    queue_cmd(CMD_ALLOC, 0, 0, '0, 0);
    queue_cmd(CMD_FREE, 0, 0, '0, 0);

    foreach (totals[p]) begin
      set_total(totals[p]);
      idle_on = !(p == 3 || p == 7);
      random_phase(165);
      if (p == 1 || p == 6) holds_asked++;
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("bitmap_first_fit_allocator test passed");
    else
      $display("bitmap_first_fit_allocator test failed");
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("bitmap_first_fit_allocator test failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/bffa_pkg.sv
rtl/core/bffa_ram.sv
rtl/core/bitmap_first_fit_allocator.sv
dv/bitmap_first_fit_allocator_tb.sv
